/* src/kec_pkg.sv */
package kec_pkg;

    // Width of the k-mer length register.
    localparam int KLEN_W = 3;
    localparam logic [KLEN_W-1:0] KLEN_RESET = 3'd7;

    // Depth of the result queue in front of the output channel.
    localparam int FIFO_DEPTH = 8;

    // Input actions.
    localparam logic ACT_FEED  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Strand selection.
    localparam logic [1:0] MODE_BOTH = 2'd0;
    localparam logic [1:0] MODE_FWD  = 2'd1;
    localparam logic [1:0] MODE_REV  = 2'd2;

    // Result kinds.
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_COUNT  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [2:0]  base_code;
        logic        first_of_sequence;
        logic [1:0]  strand_mode;
        logic [15:0] sequence_index;
        logic [19:0] base_position;
        logic [15:0] query_code;
    } t_item;

    typedef struct packed {
        logic        result_kind;
        logic [13:0] kmer_value;
        logic        reverse_strand;
        logic [15:0] record_sequence;
        logic [19:0] start_position;
        logic [31:0] occurrence_count;
        logic [31:0] records_total;
        logic        last_of_run;
    } t_result;

endpackage

/* src/kec_if.sv */
interface kec_in_if;
    logic            valid;
    logic            ready;
    kec_pkg::t_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kec_out_if;
    logic              valid;
    logic              ready;
    kec_pkg::t_result  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/kmer_extract_and_count_unit.sv */
// A result passes through slots s0 and s1 and the result queue before it is offered, a second
// record just behind it. A base of two slots (two table read-modify-writes share one port pair
// of the table memory) holds off the next input. One count query per cycle while ready is high.
// Reset (synchronous, active low) clears the windows, run, totals and queue, then sweeps
// all 4^(MAX_K+1) entries of the count table (65536 by default) to zero, one entry per cycle,
// during which no input is taken; configuration writes are taken throughout.
module kmer_extract_and_count_unit #(
    parameter int MAX_K      = 7,
    parameter int COUNT_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [kec_pkg::KLEN_W-1:0]  i_cfg_wdata,
    kec_in_if.sink                      i_in,
    kec_out_if.source                   o_out
);

    // Widths. The (K+1)-mer window doubles as the count table index.
    localparam int AW    = 2 * (MAX_K + 1);
    localparam int KW    = 2 * MAX_K;
    localparam int DEPTH = 1 << AW;
    localparam int RLW   = $clog2(MAX_K + 2);
    localparam int RSW   = $clog2(kec_pkg::FIFO_DEPTH + 1);

    localparam logic [RLW-1:0] RUN_MAX    = RLW'(MAX_K + 1);
    localparam logic [RSW-1:0] RESV_LIMIT = RSW'(kec_pkg::FIFO_DEPTH - 2);

    // One slot is one cycle's use of the table pipeline: an optional read (and
    // increment for a bump) plus an optional result carried alongside, so that
    // results leave in the order in which their inputs arrived.
    typedef struct packed {
        logic             valid;
        logic             rd;
        logic             bump;
        logic             out_en;
        logic [AW-1:0]    addr;
        kec_pkg::t_result res;
    } t_slot;

    // ---------------------------------------------------------------------
    // Architectural state
    // ---------------------------------------------------------------------
    logic [kec_pkg::KLEN_W-1:0] r_klen;
    logic [AW-1:0]              r_fwd;
    logic [AW-1:0]              r_rev;
    logic [RLW-1:0]             r_run;
    logic [31:0]                r_total;

    // Count table and its pipeline.
    logic [COUNT_BITS-1:0] r_table [DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;
    t_slot                 r_s0;
    t_slot                 r_pend;
    t_slot                 r_s1;
    logic                  r_fw_valid;
    logic [AW-1:0]         r_fw_addr;
    logic [COUNT_BITS-1:0] r_fw_data;

    // Clearing sweep after reset.
    logic                  r_clr_busy;
    logic [AW-1:0]         r_clr_addr;

    // Result queue reservation: items accepted but not yet transferred out.
    logic [RSW-1:0]        r_resv;
    logic [RSW-1:0]        n_resv;

    // ---------------------------------------------------------------------
    // Combinational signals
    // ---------------------------------------------------------------------
    logic                  w_ready;
    logic                  w_acc;
    logic                  w_pop;
    logic [RLW+2:0]        w_klen_ext;
    logic [RLW-1:0]        w_k;
    logic [RLW:0]          w_sh_k;
    logic [RLW:0]          w_sh_long;
    logic [AW-1:0]         w_long_mask;
    logic [KW-1:0]         w_short_mask;
    logic [RLW-1:0]        w_run_eff;
    logic [RLW-1:0]        w_run_new;
    logic                  w_base_bad;
    logic [1:0]            w_base;
    logic [1:0]            w_comp;
    logic [AW-1:0]         w_fw_base;
    logic [AW-1:0]         w_rv_base;
    logic [AW-1:0]         w_fw_new;
    logic [AW-1:0]         w_rv_new;
    logic [KW-1:0]         w_fwd_kmer;
    logic [KW-1:0]         w_rev_kmer;
    logic [KW+13:0]        w_fk_ext;
    logic [KW+13:0]        w_rk_ext;
    logic [AW+15:0]        w_q_ext;
    logic [19:0]           w_start;
    logic                  w_has_rec;
    logic                  w_bump;
    logic                  w_rec_f;
    logic                  w_rec_r;
    logic [31:0]           w_tot1;
    logic [31:0]           w_tot2;
    logic [31:0]           w_tot_next;
    logic [1:0]            w_items;
    t_slot                 w_slot0;
    t_slot                 w_slot1;
    logic [COUNT_BITS-1:0] w_cur;
    logic [COUNT_BITS-1:0] w_inc;
    logic                  w_mem_we;
    logic [AW-1:0]         w_mem_waddr;
    logic [COUNT_BITS-1:0] w_mem_wdata;
    kec_pkg::t_result      w_push_data;

    // ---------------------------------------------------------------------
    // Handshake. Input is taken when the table is swept clean, no second slot
    // of a base is still waiting to enter the pipeline, and the queue has room
    // for the two results that any input may produce.
    // ---------------------------------------------------------------------
    assign w_ready    = !r_clr_busy && !r_pend.valid && (r_resv <= RESV_LIMIT);
    assign i_in.ready = w_ready;
    assign w_acc      = i_in.valid && w_ready;
    assign w_pop      = o_out.valid && o_out.ready;

    // ---------------------------------------------------------------------
    // Effective K, clamped into the supported range, and the window masks.
    // ---------------------------------------------------------------------
    always_comb begin
        w_klen_ext = {{RLW{1'b0}}, r_klen};
        if (w_klen_ext < (RLW + 3)'(2)) begin
            w_k = RLW'(2);
        end else if (w_klen_ext > (RLW + 3)'(MAX_K)) begin
            w_k = RLW'(MAX_K);
        end else begin
            w_k = w_klen_ext[RLW-1:0];
        end
    end

    assign w_sh_k       = {w_k, 1'b0};
    assign w_sh_long    = w_sh_k + (RLW + 1)'(2);
    assign w_long_mask  = ~({AW{1'b1}} << w_sh_long);
    assign w_short_mask = ~({KW{1'b1}} << w_sh_k);

    // ---------------------------------------------------------------------
    // Rolling windows. The forward window shifts each new base in at the
    // bottom; the reverse window shifts down and places the complement of the
    // new base at base slot K, so its top K bases form the reverse k-mer.
    // A new sequence or an empty run starts both windows from zero.
    // ---------------------------------------------------------------------
    assign w_run_eff  = i_in.data.first_of_sequence ? '0 : r_run;
    assign w_base_bad = i_in.data.base_code[2];
    assign w_base     = i_in.data.base_code[1:0];
    assign w_comp     = w_base ^ 2'b11;
    assign w_fw_base  = (w_run_eff == '0) ? '0 : r_fwd;
    assign w_rv_base  = (w_run_eff == '0) ? '0 : r_rev;
    assign w_fw_new   = ((w_fw_base << 2) | AW'(w_base)) & w_long_mask;
    assign w_rv_new   = ((w_rv_base >> 2) | (AW'(w_comp) << w_sh_k)) & w_long_mask;
    assign w_run_new  = (w_run_eff == RUN_MAX) ? w_run_eff : w_run_eff + RLW'(1);

    assign w_fwd_kmer = w_fw_new[KW-1:0] & w_short_mask;
    assign w_rev_kmer = w_rv_new[AW-1:2];
    assign w_fk_ext   = {14'd0, w_fwd_kmer};
    assign w_rk_ext   = {14'd0, w_rev_kmer};
    assign w_q_ext    = {{AW{1'b0}}, i_in.data.query_code};

    // The k-mer starts K-1 bases back; this wraps for early positions.
    assign w_start    = i_in.data.base_position - 20'(w_k) + 20'd1;

    // Records once K bases are in the run, counting once K+1 are.
    assign w_has_rec  = (w_run_new >= w_k);
    assign w_bump     = (w_run_new > w_k);
    assign w_rec_f    = w_has_rec && ((i_in.data.strand_mode == kec_pkg::MODE_BOTH) ||
                                      (i_in.data.strand_mode == kec_pkg::MODE_FWD));
    assign w_rec_r    = w_has_rec && ((i_in.data.strand_mode == kec_pkg::MODE_BOTH) ||
                                      (i_in.data.strand_mode == kec_pkg::MODE_REV));

    // Saturating record totals for the first and second record of this base.
    assign w_tot1 = (r_total == '1) ? r_total : r_total + 32'd1;
    assign w_tot2 = (w_tot1 == '1) ? w_tot1 : w_tot1 + 32'd1;

    // ---------------------------------------------------------------------
    // Slot building. A query is one slot. A base is up to two slots: the
    // first bumps the forward (K+1)-mer and carries the first record, the
    // second bumps the reverse complement and carries the second record.
    // ---------------------------------------------------------------------
    always_comb begin
        w_slot0    = '0;
        w_slot1    = '0;
        w_items    = 2'd0;
        w_tot_next = r_total;
        if (i_in.data.action == kec_pkg::ACT_QUERY) begin
            w_slot0.valid                = 1'b1;
            w_slot0.rd                   = 1'b1;
            w_slot0.out_en               = 1'b1;
            w_slot0.addr                 = w_q_ext[AW-1:0];
            w_slot0.res.result_kind      = kec_pkg::KIND_COUNT;
            w_slot0.res.records_total    = r_total;
            w_slot0.res.last_of_run      = 1'b1;
            w_items                      = 2'd1;
        end else if (!w_base_bad) begin
            w_slot0.valid = 1'b1;
            w_slot0.rd    = w_bump;
            w_slot0.bump  = w_bump;
            w_slot0.addr  = w_fw_new;
            w_slot1.valid = w_bump || (w_rec_f && w_rec_r);
            w_slot1.rd    = w_bump;
            w_slot1.bump  = w_bump;
            w_slot1.addr  = w_rv_new;
            if (w_rec_f || w_rec_r) begin
                w_slot0.out_en              = 1'b1;
                w_slot0.res.result_kind     = kec_pkg::KIND_RECORD;
                w_slot0.res.kmer_value      = w_rec_f ? w_fk_ext[13:0] : w_rk_ext[13:0];
                w_slot0.res.reverse_strand  = !w_rec_f;
                w_slot0.res.record_sequence = i_in.data.sequence_index;
                w_slot0.res.start_position  = w_start;
                w_slot0.res.records_total   = w_tot1;
                w_slot0.res.last_of_run     = !(w_rec_f && w_rec_r);
                w_tot_next                  = w_tot1;
                w_items                     = 2'd1;
            end
            if (w_rec_f && w_rec_r) begin
                w_slot1.out_en              = 1'b1;
                w_slot1.res.result_kind     = kec_pkg::KIND_RECORD;
                w_slot1.res.kmer_value      = w_rk_ext[13:0];
                w_slot1.res.reverse_strand  = 1'b1;
                w_slot1.res.record_sequence = i_in.data.sequence_index;
                w_slot1.res.start_position  = w_start;
                w_slot1.res.records_total   = w_tot2;
                w_slot1.res.last_of_run     = 1'b1;
                w_tot_next                  = w_tot2;
                w_items                     = 2'd2;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Window, run, length register and record total.
    // Writing the length register clears the run; the table is kept.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen  <= kec_pkg::KLEN_RESET;
            r_fwd   <= '0;
            r_rev   <= '0;
            r_run   <= '0;
            r_total <= '0;
        end else if (i_cfg_we) begin
            r_klen <= i_cfg_wdata;
            r_fwd  <= '0;
            r_rev  <= '0;
            r_run  <= '0;
        end else if (w_acc && (i_in.data.action == kec_pkg::ACT_FEED)) begin
            r_total <= w_tot_next;
            if (w_base_bad) begin
                r_run <= '0;
            end else begin
                r_run <= w_run_new;
                r_fwd <= w_fw_new;
                r_rev <= w_rv_new;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Slot pipeline: s0 issues the table read, s1 sees the read data,
    // increments it and writes it back, and hands its result to the queue.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0       <= '0;
            r_pend     <= '0;
            r_s1       <= '0;
            r_fw_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_s0   <= w_slot0;
                r_pend <= w_slot1;
            end else begin
                r_s0         <= r_pend;
                r_pend.valid <= 1'b0;
            end
            r_s1       <= r_s0;
            r_fw_valid <= r_s1.valid && r_s1.bump;
        end
    end

    // The write from s1 lands at the same edge as the read issued from s0,
    // so that read returns the old value; the registered copy of the write
    // replaces it when the addresses meet. Earlier writes are already in
    // the memory by the time of the read.
    always_ff @(posedge i_clk) begin
        r_fw_addr <= r_s1.addr;
        r_fw_data <= w_inc;
    end

    assign w_cur = (r_fw_valid && (r_fw_addr == r_s1.addr)) ? r_fw_data : r_rd_data;
    assign w_inc = (w_cur == '1) ? w_cur : w_cur + COUNT_BITS'(1);

    // Write port: the clearing sweep after reset, then the bumps.
    assign w_mem_we    = r_clr_busy || (r_s1.valid && r_s1.bump);
    assign w_mem_waddr = r_clr_busy ? r_clr_addr : r_s1.addr;
    assign w_mem_wdata = r_clr_busy ? '0 : w_inc;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_table[w_mem_waddr] <= w_mem_wdata;
        end
        if (r_s0.valid && r_s0.rd) begin
            r_rd_data <= r_table[r_s0.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result queue. Space is reserved at input transfer, so a slot reaching
    // s1 always finds room and the pipeline never stalls.
    // ---------------------------------------------------------------------
    always_comb begin
        w_push_data = r_s1.res;
        if (r_s1.rd && (r_s1.res.result_kind == kec_pkg::KIND_COUNT)) begin
            w_push_data.occurrence_count = 32'(w_cur);
        end
    end

    kec_fifo #(
        .DEPTH (kec_pkg::FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1.valid && r_s1.out_en),
        .i_push_data (w_push_data),
        .o_out       (o_out)
    );

    assign n_resv = r_resv + (w_acc ? RSW'(w_items) : RSW'(0)) - RSW'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resv <= '0;
        end else begin
            r_resv <= n_resv;
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_resv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_resv <= RSW'(kec_pkg::FIFO_DEPTH))
        else $error("result reservation exceeds queue depth");

    a_no_input_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_in.ready)
        else $error("input taken during table clearing");

    a_pend_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend.valid |=> (r_s0.valid && !r_pend.valid))
        else $error("second slot of a base did not enter the pipeline");

    a_no_bump_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !(r_s1.valid && r_s1.bump))
        else $error("count bump collides with table clearing");

endmodule

/* src/kec_fifo.sv */
module kec_fifo #(
    parameter int DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  kec_pkg::t_result  i_push_data,
    kec_out_if.source         o_out
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    kec_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_pop;

    assign o_out.valid = (r_cnt != '0);
    assign o_out.data  = r_mem[r_rd];
    assign w_pop       = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(w_pop);
        end
    end

endmodule

/* tb/sv/kec_result_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the k-mer unit, keeps its own copy of the windows,
// run length and count table, and checks every result transfer in order.
module kec_result_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [kec_pkg::KLEN_W-1:0]  i_cfg_wdata,
    kec_in_if                           i_feed,
    kec_out_if                          i_result,
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam int WIN_MAX     = 7;
    localparam int TABLE_DEPTH = 1 << (2 * (WIN_MAX + 1));

    logic [kec_pkg::KLEN_W-1:0] klen;
    logic [15:0]                fwd_win;
    logic [15:0]                rev_win;
    logic [3:0]                 run_len;
    logic [31:0]                tally [TABLE_DEPTH];
    logic [31:0]                records_seen;
    kec_pkg::t_result           awaited [$];
    int                         fails = 0;

    // Appends one expected result at the tail of the queue.
    function automatic void queue_result(kec_pkg::t_result r);
        awaited.insert(awaited.size(), r);
    endfunction

    function automatic void bump_tally(logic [15:0] idx);
        if (tally[idx] != '1) begin
            tally[idx] = tally[idx] + 32'd1;
        end
    endfunction

    function automatic kec_pkg::t_result make_record(logic [13:0] value, logic rev,
                                                     logic [15:0] seq, logic [19:0] start);
        kec_pkg::t_result r;
        if (records_seen != '1) begin
            records_seen = records_seen + 32'd1;
        end
        r = '0;
        r.result_kind     = kec_pkg::KIND_RECORD;
        r.kmer_value      = value;
        r.reverse_strand  = rev;
        r.record_sequence = seq;
        r.start_position  = start;
        r.records_total   = records_seen;
        return r;
    endfunction

    // Works out what one accepted item should produce and queues it.
    function automatic void derive_results(kec_pkg::t_item it);
        int unsigned      k;
        logic [15:0]      long_m;
        logic [15:0]      short_m;
        logic [1:0]       comp;
        logic [19:0]      start;
        kec_pkg::t_result r;
        kec_pkg::t_result recs [2];
        int               n;
        k       = (klen < 2) ? 2 : ((klen > WIN_MAX) ? WIN_MAX : klen);
        long_m  = 16'((32'd1 << (2 * (k + 1))) - 1);
        short_m = 16'((32'd1 << (2 * k)) - 1);
        n       = 0;
        if (it.action == kec_pkg::ACT_QUERY) begin
            r = '0;
            r.result_kind      = kec_pkg::KIND_COUNT;
            r.occurrence_count = tally[it.query_code];
            r.records_total    = records_seen;
            r.last_of_run      = 1'b1;
            queue_result(r);
            return;
        end
        if (it.first_of_sequence) begin
            run_len = '0;
        end
        // An unknown base only breaks the run.
        if (it.base_code[2]) begin
            run_len = '0;
            return;
        end
        if (run_len == 0) begin
            fwd_win = '0;
            rev_win = '0;
        end
        comp    = it.base_code[1:0] ^ 2'b11;
        fwd_win = ((fwd_win << 2) | 16'(it.base_code[1:0])) & long_m;
        rev_win = ((rev_win >> 2) | (16'(comp) << (2 * k))) & long_m;
        if (run_len < WIN_MAX + 1) begin
            run_len = run_len + 4'd1;
        end
        if (run_len >= k) begin
            start = it.base_position - 20'(k - 1);
            if (it.strand_mode == kec_pkg::MODE_BOTH || it.strand_mode == kec_pkg::MODE_FWD) begin
                recs[n] = make_record(14'(fwd_win & short_m), 1'b0, it.sequence_index, start);
                n++;
            end
            if (it.strand_mode == kec_pkg::MODE_BOTH || it.strand_mode == kec_pkg::MODE_REV) begin
                recs[n] = make_record(14'(rev_win >> 2), 1'b1, it.sequence_index, start);
                n++;
            end
        end
        if (run_len >= k + 1) begin
            bump_tally(fwd_win);
            bump_tally(rev_win);
        end
        if (n > 0) begin
            recs[n-1].last_of_run = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            queue_result(recs[i]);
        end
    endfunction

    function automatic void check_result(kec_pkg::t_result got);
        kec_pkg::t_result want;
        if (awaited.size() == 0) begin
            fails++;
            if (fails <= 10) begin
                $display("%0t: unexpected result kind %0d kmer %h rev %0d seq %h start %h",
                         $time, got.result_kind, got.kmer_value, got.reverse_strand,
                         got.record_sequence, got.start_position);
            end
            return;
        end
        want = awaited.pop_front();
        if (got.result_kind !== want.result_kind || got.kmer_value !== want.kmer_value ||
            got.reverse_strand !== want.reverse_strand ||
            got.record_sequence !== want.record_sequence ||
            got.start_position !== want.start_position ||
            got.occurrence_count !== want.occurrence_count ||
            got.records_total !== want.records_total ||
            got.last_of_run !== want.last_of_run) begin
            fails++;
            if (fails <= 10) begin
                $display("%0t: result mismatch", $time);
                $display("  expected kind %0d kmer %h rev %0d seq %h start %h",
                         want.result_kind, want.kmer_value, want.reverse_strand,
                         want.record_sequence, want.start_position);
                $display("           cnt %0d tot %0d last %0d",
                         want.occurrence_count, want.records_total, want.last_of_run);
                $display("  actual   kind %0d kmer %h rev %0d seq %h start %h",
                         got.result_kind, got.kmer_value, got.reverse_strand,
                         got.record_sequence, got.start_position);
                $display("           cnt %0d tot %0d last %0d",
                         got.occurrence_count, got.records_total, got.last_of_run);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            klen         = kec_pkg::KLEN_RESET;
            fwd_win      = '0;
            rev_win      = '0;
            run_len      = '0;
            records_seen = '0;
            awaited.delete();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                tally[i] = '0;
            end
        end else begin
            // A length write clears the run but keeps the table.
            if (i_cfg_we) begin
                klen    = i_cfg_wdata;
                run_len = '0;
                fwd_win = '0;
                rev_win = '0;
            end
            if (i_feed.valid && i_feed.ready) begin
                derive_results(i_feed.data);
            end
            if (i_result.valid && i_result.ready) begin
                check_result(i_result.data);
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited.size();
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

// Top of the k-mer unit testbench. It makes the stimulus, paces both sides of
// the block and gives the verdict; all prediction and comparison is done in
// the result checker that sits beside the block.
module tb_top;

    // Base codes as they travel on the input channel. Any code with the top
    // bit set is an unknown base; both ends of that range are used.
    localparam logic [2:0] BASE_A = 3'd0;
    localparam logic [2:0] BASE_C = 3'd1;
    localparam logic [2:0] BASE_G = 3'd2;
    localparam logic [2:0] BASE_T = 3'd3;
    localparam logic [2:0] BASE_N = 3'd4;
    localparam logic [2:0] BASE_X = 3'd7;

    // The fourth strand mode: no records, but counting carries on.
    localparam logic [1:0] MODE_NONE = 2'd3;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [kec_pkg::KLEN_W-1:0] cfg_wdata;
    int                         fail_count;
    int                         pending;
    int                         sent_total;
    bit                         steady;
    bit                         hold_req;
    logic [15:0]                hist;

    kec_in_if  in_ch ();
    kec_out_if out_ch ();

    kmer_extract_and_count_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    kec_result_checker result_watch (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_feed       (in_ch),
        .i_result     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock.
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offers one item and returns in the time step of its transfer. Before the
    // offer the sender may idle; every 32 items it draws afresh whether the
    // next stretch runs without any idling at all. The valid line is left
    // high so that back-to-back offers never lower and raise it within one
    // time step.
    task automatic send_item(input kec_pkg::t_item it);
        int gap;
        if (sent_total % 32 == 0) begin
            steady = ($urandom_range(0, 3) == 0);
        end
        gap = steady ? 0 : $urandom_range(0, 6);
        sent_total++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Feeds one base. The query field is unused here, so it carries noise.
    // The last bases seen are kept so that queries can ask for counts that
    // have really been made.
    task automatic feed(input logic [2:0] base, input bit first, input logic [1:0] mode,
                        input logic [15:0] seq, input logic [19:0] pos);
        kec_pkg::t_item it;
        it.action            = kec_pkg::ACT_FEED;
        it.base_code         = base;
        it.first_of_sequence = first;
        it.strand_mode       = mode;
        it.sequence_index    = seq;
        it.base_position     = pos;
        it.query_code        = 16'($urandom);
        if (!base[2]) begin
            hist = {hist[13:0], base[1:0]};
        end
        send_item(it);
    endtask

    // Reads one count back; every field but the code is noise.
    task automatic ask(input logic [15:0] code);
        kec_pkg::t_item it;
        it.action            = kec_pkg::ACT_QUERY;
        it.base_code         = 3'($urandom);
        it.first_of_sequence = 1'($urandom);
        it.strand_mode       = 2'($urandom);
        it.sequence_index    = 16'($urandom);
        it.base_position     = 20'($urandom);
        it.query_code        = code;
        send_item(it);
    endtask

    // Drops valid and waits until every expected result has been transferred.
    // An unknown base gives no result, so the task waits on afterwards for
    // the block to finish with it before the length register is touched.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_klen(input logic [kec_pkg::KLEN_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One phase of random traffic under a given k-mer length. Most of it is
    // runs of real bases, so that the windows fill and both records and
    // counts appear; unknown bases, stray sequence starts and queries are
    // mixed in. Some runs draw from two bases only or repeat a short motif,
    // which makes the same (K+1)-mers come back and the counts climb. When
    // asked, a third of the way in, the receiver is told to hold off for a
    // long while so that the result queue fills and the input stalls.
    task automatic random_phase(input logic [kec_pkg::KLEN_W-1:0] setting, input int n_items,
                                input bit squeeze);
        int          sent;
        int          run_len;
        int          k_eff;
        int          pick;
        int          alpha;
        bit          held;
        bit          first;
        logic [1:0]  mode;
        logic [2:0]  base;
        logic [7:0]  motif;
        logic [15:0] seq;
        logic [15:0] long_m;
        logic [15:0] qcode;
        logic [19:0] pos;
        settle();
        write_klen(setting);
        k_eff  = (setting < 2) ? 2 : setting;
        long_m = 16'((32'd1 << (2 * (k_eff + 1))) - 1);
        sent   = 0;
        held   = 1'b0;
        while (sent < n_items) begin
            run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 40)
                                                  : $urandom_range(1, 12);
            mode    = ($urandom_range(0, 7) == 0) ? MODE_NONE : 2'($urandom_range(0, 2));
            seq     = 16'($urandom);
            pick    = $urandom_range(0, 9);
            // Positions near zero make the start position wrap; positions
            // near the top of the range wrap the base position itself.
            if (pick < 3) begin
                pos = 20'($urandom_range(0, 3));
            end else if (pick == 3) begin
                pos = 20'hFFFFF - 20'($urandom_range(0, 40));
            end else begin
                pos = 20'($urandom);
            end
            alpha = $urandom_range(0, 3);
            motif = 8'($urandom);
            for (int b = 0; b < run_len && sent < n_items; b++) begin
                if (squeeze && !held && sent >= n_items / 3) begin
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                if ($urandom_range(0, 9) == 0) begin
                    pick = $urandom_range(0, 3);
                    if (pick < 2) begin
                        qcode = hist & long_m;
                    end else if (pick == 2) begin
                        qcode = 16'($urandom) & long_m;
                    end else begin
                        qcode = 16'($urandom);
                    end
                    ask(qcode);
                    sent++;
                end
                if ($urandom_range(0, 29) == 0) begin
                    base = 3'($urandom_range(4, 7));
                end else if (alpha == 1) begin
                    base = 3'($urandom_range(0, 1));
                end else if (alpha == 2) begin
                    base = {1'b0, motif[2 * (b % 4) +: 2]};
                end else begin
                    base = 3'($urandom_range(0, 3));
                end
                // Most runs open a new sequence; some simply carry on from the
                // previous one, and now and then a sequence starts mid-run.
                first = (b == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 39) == 0);
                feed(base, first, mode, seq, pos);
                pos = pos + 20'd1;
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        int guard;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= kec_pkg::KLEN_RESET;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        hist        = '0;
        sent_total  = 0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under K = 3. The block is still sweeping its count
        // table at this point; the first item simply waits for it to finish.
        write_klen(3'd3);
        // ACGT is its own reverse complement, so its count goes up by two.
        feed(BASE_A, 1'b1, kec_pkg::MODE_BOTH, 16'h0000, 20'h00000);
        feed(BASE_C, 1'b0, kec_pkg::MODE_BOTH, 16'h0000, 20'h00001);
        feed(BASE_G, 1'b0, kec_pkg::MODE_BOTH, 16'h0000, 20'h00002);
        feed(BASE_T, 1'b0, kec_pkg::MODE_BOTH, 16'h0000, 20'h00003);
        ask(16'({BASE_A[1:0], BASE_C[1:0], BASE_G[1:0], BASE_T[1:0]}));
        // An entry that no 4-mer can ever reach.
        ask(16'hFFFF);
        // New sequence, one strand at a time; the third base sits so early in
        // its sequence that the start position wraps round.
        feed(BASE_T, 1'b1, kec_pkg::MODE_FWD, 16'hFFFF, 20'h00000);
        feed(BASE_T, 1'b0, kec_pkg::MODE_FWD, 16'hFFFF, 20'h00001);
        feed(BASE_T, 1'b0, kec_pkg::MODE_REV, 16'hFFFF, 20'h00001);
        // Strand mode three: nothing comes out, but TTTA is still counted.
        feed(BASE_A, 1'b0, MODE_NONE, 16'hFFFF, 20'hFFFFF);
        ask(16'({BASE_T[1:0], BASE_T[1:0], BASE_T[1:0], BASE_A[1:0]}));
        // Unknown bases break the run, with and without a sequence start.
        feed(BASE_X, 1'b0, kec_pkg::MODE_BOTH, 16'h5A5A, 20'hFFFFD);
        feed(BASE_C, 1'b0, kec_pkg::MODE_BOTH, 16'h5A5A, 20'hFFFFE);
        feed(BASE_G, 1'b0, kec_pkg::MODE_BOTH, 16'h5A5A, 20'hFFFFF);
        feed(BASE_C, 1'b0, kec_pkg::MODE_BOTH, 16'h5A5A, 20'h00000);
        feed(BASE_N, 1'b1, kec_pkg::MODE_BOTH, 16'hA5A5, 20'h00000);
        feed(BASE_G, 1'b0, kec_pkg::MODE_REV, 16'hA5A5, 20'h00001);
        ask(16'h0000);

        // Random part. Each phase sets a new k-mer length, so every value of
        // the register is written, the two below the usable range among them.
        random_phase(3'd2, 160, 1'b0);
        random_phase(3'd0, 160, 1'b0);
        random_phase(3'd7, 160, 1'b0);
        random_phase(3'd1, 160, 1'b0);
        random_phase(3'd5, 160, 1'b1);
        random_phase(3'd4, 160, 1'b0);
        random_phase(3'd6, 160, 1'b0);
        random_phase(3'd3, 160, 1'b1);

        // Drain whatever is left, then allow the latency once more.
        in_ch.valid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (pending != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** kmer_extract_and_count_unit: PASSED **");
        end else begin
            $display("** kmer_extract_and_count_unit: FAILED **");
        end
        $finish;
    end

    // Receiver. Before each transfer it may hold ready low, with stretches of no
    // holding at all. When the sender asks for it, it holds off long enough for
    // the result queue to fill and the block to refuse further input.
    initial begin : drain
        int taken;
        int gap;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (taken % 32 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            gap = calm ? 0 : $urandom_range(0, 6);
            if (hold_req) begin
                hold_req = 1'b0;
                gap      = 300;
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            taken++;
        end
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        #7_200_000;
        $display("** kmer_extract_and_count_unit: FAILED **");
        $finish;
    end

endmodule

/* files.f */
src/kec_pkg.sv
src/kec_if.sv
src/kec_fifo.sv
src/kmer_extract_and_count_unit.sv
tb/sv/kec_result_checker.sv
tb/sv/tb_top.sv
